>>> hdl/ifd_pkg.sv
// shared types and constants for the frame deframer
`default_nettype none

package ifd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 16;
  localparam int unsigned CfgIdxW = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegSync = 2'd0;
  localparam logic [CfgIdxW-1:0] RegOwn  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegPeer = 2'd2;

  // configuration reset values
  localparam logic [ByteW-1:0] SyncRst = 8'd20;
  localparam logic [ByteW-1:0] OwnRst  = 8'd12;
  localparam logic [ByteW-1:0] PeerRst = 8'd0;

  typedef enum logic [2:0] {
    PhHunt  = 3'd0,
    PhDest  = 3'd1,
    PhSrc   = 3'd2,
    PhType  = 3'd3,
    PhLenHi = 3'd4,
    PhLenLo = 3'd5,
    PhData  = 3'd6
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] payload_byte;
    logic [ByteW-1:0] frame_type;
    logic [LenW-1:0]  payload_len;
    logic             is_last;
    logic             is_empty;
  } result_t;

  typedef struct packed {
    logic    push;
    result_t res;
  } push_t;

endpackage

`default_nettype wire

>>> hdl/ifd_parser.sv
// header parser: config registers, parse phase and message counters
`default_nettype none

module ifd_parser (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [ifd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [ifd_pkg::ByteW-1:0]   cfg_data_i,
  input  wire logic                        accept_i,
  input  wire logic [ifd_pkg::ByteW-1:0]   rx_data_i,
  output ifd_pkg::push_t                   push_o
);

  logic [ifd_pkg::ByteW-1:0] sync_q, own_q, peer_q;
  ifd_pkg::phase_e           phase_q, phase_d;
  logic [ifd_pkg::ByteW-1:0] type_q, type_d;
  logic [ifd_pkg::LenW-1:0]  len_q, len_d;
  logic [ifd_pkg::LenW-1:0]  cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= ifd_pkg::SyncRst;
      own_q  <= ifd_pkg::OwnRst;
      peer_q <= ifd_pkg::PeerRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ifd_pkg::RegSync: sync_q <= cfg_data_i;
        ifd_pkg::RegOwn:  own_q  <= cfg_data_i;
        ifd_pkg::RegPeer: peer_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ifd_pkg::PhHunt;
      type_q  <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      type_q  <= type_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    phase_d = phase_q;
    type_d  = type_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    push_o  = '0;
    unique case (phase_q)
      ifd_pkg::PhDest: phase_d = (rx_data_i == own_q) ? ifd_pkg::PhSrc : ifd_pkg::PhHunt;
      ifd_pkg::PhSrc:  phase_d = (rx_data_i == peer_q) ? ifd_pkg::PhType : ifd_pkg::PhHunt;
      ifd_pkg::PhType: begin
        type_d  = rx_data_i;
        phase_d = ifd_pkg::PhLenHi;
      end
      ifd_pkg::PhLenHi: begin
        len_d   = {rx_data_i, {ifd_pkg::ByteW{1'b0}}};
        phase_d = ifd_pkg::PhLenLo;
      end
      ifd_pkg::PhLenLo: begin
        len_d = {len_q[ifd_pkg::LenW-1:ifd_pkg::ByteW], rx_data_i};
        if (len_d == '0) begin
          // empty message gives a single closing result
          push_o.push             = 1'b1;
          push_o.res.payload_byte = '0;
          push_o.res.frame_type   = type_q;
          push_o.res.payload_len  = len_d;
          push_o.res.is_last      = 1'b1;
          push_o.res.is_empty     = 1'b1;
          phase_d                 = ifd_pkg::PhHunt;
        end else begin
          phase_d = ifd_pkg::PhData;
        end
      end
      ifd_pkg::PhData: begin
        cnt_d                   = cnt_q + ifd_pkg::LenW'(1);
        push_o.push             = 1'b1;
        push_o.res.payload_byte = rx_data_i;
        push_o.res.frame_type   = type_q;
        push_o.res.payload_len  = len_q;
        push_o.res.is_last      = (cnt_d >= len_q);
        push_o.res.is_empty     = 1'b0;
        if (push_o.res.is_last) phase_d = ifd_pkg::PhHunt;
      end
      default: begin
        // hunt, and the unused code
        if (rx_data_i == sync_q) begin
          cnt_d   = '0;
          phase_d = ifd_pkg::PhDest;
        end else begin
          phase_d = ifd_pkg::PhHunt;
        end
      end
    endcase
    // a result is only produced by a byte that is actually taken
    if (!accept_i) push_o.push = 1'b0;
  end

endmodule

`default_nettype wire

>>> hdl/ifd_out_buf.sv
// result register with one skid entry
`default_nettype none

module ifd_out_buf (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  ifd_pkg::push_t  push_i,
  output logic            full_o,
  output logic            valid_o,
  input  wire logic       stall_i,
  output ifd_pkg::result_t res_o
);

  logic             main_vld_q, skid_vld_q;
  ifd_pkg::result_t main_q, skid_q;
  logic             pop;

  assign pop     = main_vld_q && !stall_i;
  assign valid_o = main_vld_q;
  assign res_o   = main_q;
  assign full_o  = skid_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (pop) skid_vld_q <= 1'b0;
    end else if (push_i.push) begin
      if (!main_vld_q || pop) main_vld_q <= 1'b1;
      else skid_vld_q <= 1'b1;
    end else if (pop) begin
      main_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (pop) main_q <= skid_q;
    end else if (push_i.push) begin
      if (!main_vld_q || pop) main_q <= push_i.res;
      else skid_q <= push_i.res;
    end
  end

endmodule

`default_nettype wire

>>> hdl/irda_frame_deframer_unit.sv
// top level of the receive frame deframer
//
// receive-side frame parser: one byte is taken per cycle while the skid entry
// is free, and each header or payload byte is handled in the cycle it is
// accepted by the phase register and a few byte compares plus a 16-bit count
// compare. a result is registered, in the skid entry if the output stalls.
// the output side is a result register backed by one skid entry, so bytes
// keep flowing while a result waits; in_stall_o rises only while the skid
// entry is occupied. configuration writes take effect on the next cycle and
// are meant for idle periods. no clearing pass is needed after reset.
`default_nettype none

module irda_frame_deframer_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration
  input  wire logic                        cfg_we_i,
  input  wire logic [ifd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [ifd_pkg::ByteW-1:0]   cfg_data_i,
  // received bytes
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [ifd_pkg::ByteW-1:0]   rx_data_i,
  // results
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [ifd_pkg::ByteW-1:0]        payload_byte_o,
  output logic [ifd_pkg::ByteW-1:0]        frame_type_o,
  output logic [ifd_pkg::LenW-1:0]         payload_len_o,
  output logic                             is_last_o,
  output logic                             is_empty_o
);

  logic             accept;
  ifd_pkg::push_t   push;
  ifd_pkg::result_t res;

  // a byte is taken whenever the skid entry is free
  assign accept = in_valid_i && !in_stall_o;

  ifd_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .rx_data_i  (rx_data_i),
    .push_o     (push)
  );

  ifd_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (in_stall_o),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .res_o   (res)
  );

  // result fields straight from the result register
  assign payload_byte_o = res.payload_byte;
  assign frame_type_o   = res.frame_type;
  assign payload_len_o  = res.payload_len;
  assign is_last_o      = res.is_last;
  assign is_empty_o     = res.is_empty;

endmodule

`default_nettype wire

>>> hdl/ifd_checker.sv
// port-level checks for the frame deframer, bound to the top level
`default_nettype none

module ifd_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_stall_o,
  input wire logic                      out_valid_o,
  input wire logic                      out_stall_i,
  input wire logic [ifd_pkg::ByteW-1:0] payload_byte_o,
  input wire logic [ifd_pkg::LenW-1:0]  payload_len_o,
  input wire logic                      is_last_o,
  input wire logic                      is_empty_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // the empty result closes a zero-length message with a zero byte
  a_empty_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_empty_o |-> is_last_o && payload_byte_o == '0 &&
    payload_len_o == '0)
    else $error("malformed empty result");

  // payload results only come from messages with a nonzero length
  a_payload_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_empty_o |-> payload_len_o != '0)
    else $error("payload result with zero length");

  // input stalls only while a result is waiting
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

endmodule

bind irda_frame_deframer_unit ifd_checker u_ifd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .payload_byte_o (payload_byte_o),
  .payload_len_o  (payload_len_o),
  .is_last_o      (is_last_o),
  .is_empty_o     (is_empty_o)
);

`default_nettype wire
